// ----- sv/imu_gf_pkg.sv -----
package imu_gf_pkg;

    localparam int NUM_AXES   = 6;
    localparam int AXIS_IDX_W = 3;

    localparam logic [AXIS_IDX_W-1:0] FIRST_AXIS = AXIS_IDX_W'(0);
    localparam logic [AXIS_IDX_W-1:0] LAST_AXIS  = AXIS_IDX_W'(NUM_AXES - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_COUNT = 8'b0000_0100,
        S_DIV_T = 8'b0000_1000,
        S_DIV_A = 8'b0001_0000,
        S_ADV   = 8'b0010_0000,
        S_FILL  = 8'b0100_0000,
        S_LAST  = 8'b1000_0000
    } t_state;

    // sequencer to interpolation stepper
    typedef struct packed {
        logic                  clear;
        logic                  advance;
        logic                  load_time;
        logic                  load_axis;
        logic [AXIS_IDX_W-1:0] axis;
    } t_step_ctrl;

endpackage

// ----- sv/imu_gf_divider.sv -----
module imu_gf_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 5,
    localparam int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,   // left aligned
    input  logic [CNT_W-1:0] i_len,   // quotient bits to produce
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = trial >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_num  = i_num;
            n_quo  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = i_len;
        end else if (r_busy) begin
            n_num = r_num << 1;
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- sv/imu_gf_stepper.sv -----
module imu_gf_stepper
    import imu_gf_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32,
    parameter int DEN_W       = 5,
    parameter int NUM_W       = 32
) (
    input  logic                          i_clk,
    input  t_step_ctrl                    i_ctrl,
    input  logic [NUM_W-1:0]              i_quo,
    input  logic [DEN_W-1:0]              i_rem,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [TIME_BITS-1:0]          i_prev_time,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_axis [NUM_AXES],
    input  logic [NUM_AXES-1:0]           i_neg,
    output logic [TIME_BITS-1:0]          o_time,
    output logic signed [SAMPLE_BITS-1:0] o_axis [NUM_AXES]
);

    // per step increments (quotient, remainder of value / den)
    logic [TIME_BITS-1:0]   r_tq;
    logic [DEN_W-1:0]       r_tr;
    logic [SAMPLE_BITS-1:0] r_aq [NUM_AXES];
    logic [DEN_W-1:0]       r_ar [NUM_AXES];
    // running k * value / den
    logic [TIME_BITS-1:0]   r_tacc_q, n_tacc_q;
    logic [DEN_W-1:0]       r_tacc_r, n_tacc_r;
    logic [SAMPLE_BITS-1:0] r_aacc_q [NUM_AXES];
    logic [SAMPLE_BITS-1:0] n_aacc_q [NUM_AXES];
    logic [DEN_W-1:0]       r_aacc_r [NUM_AXES];
    logic [DEN_W-1:0]       n_aacc_r [NUM_AXES];

    logic [DEN_W:0]         t_sum;
    logic [DEN_W:0]         t_red;
    logic                   t_wrap;
    logic [DEN_W:0]         a_sum [NUM_AXES];
    logic [DEN_W:0]         a_red [NUM_AXES];
    logic                   a_wrap [NUM_AXES];
    logic [DEN_W-1:0]       half;
    logic                   rnd [NUM_AXES];
    logic [SAMPLE_BITS:0]   adj [NUM_AXES];
    logic [SAMPLE_BITS:0]   base [NUM_AXES];
    logic [SAMPLE_BITS:0]   res [NUM_AXES];

    always_comb begin
        t_sum    = {1'b0, r_tacc_r} + {1'b0, r_tr};
        t_red    = t_sum - {1'b0, i_den};
        t_wrap   = t_sum >= {1'b0, i_den};
        n_tacc_q = r_tacc_q + r_tq + TIME_BITS'(t_wrap);
        n_tacc_r = t_wrap ? t_red[DEN_W-1:0] : t_sum[DEN_W-1:0];
        half     = i_den >> 1;
        o_time   = i_prev_time + r_tacc_q;
        for (int i = 0; i < NUM_AXES; i++) begin
            a_sum[i]    = {1'b0, r_aacc_r[i]} + {1'b0, r_ar[i]};
            a_red[i]    = a_sum[i] - {1'b0, i_den};
            a_wrap[i]   = a_sum[i] >= {1'b0, i_den};
            n_aacc_q[i] = r_aacc_q[i] + r_aq[i] + SAMPLE_BITS'(a_wrap[i]);
            n_aacc_r[i] = a_wrap[i] ? a_red[i][DEN_W-1:0] : a_sum[i][DEN_W-1:0];
            // round half away from zero on the magnitude
            rnd[i]  = ({1'b0, r_aacc_r[i]} + {1'b0, half}) >= {1'b0, i_den};
            adj[i]  = {1'b0, r_aacc_q[i]} + (SAMPLE_BITS + 1)'(rnd[i]);
            base[i] = {i_prev_axis[i][SAMPLE_BITS-1], i_prev_axis[i]};
            res[i]  = i_neg[i] ? base[i] - adj[i] : base[i] + adj[i];
            o_axis[i] = res[i][SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_tacc_q <= '0;
            r_tacc_r <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_aacc_q[i] <= '0;
                r_aacc_r[i] <= '0;
            end
        end else if (i_ctrl.advance) begin
            r_tacc_q <= n_tacc_q;
            r_tacc_r <= n_tacc_r;
            r_aacc_q <= n_aacc_q;
            r_aacc_r <= n_aacc_r;
        end
        if (i_ctrl.load_time) begin
            r_tq <= i_quo[TIME_BITS-1:0];
            r_tr <= i_rem;
        end
        if (i_ctrl.load_axis) begin
            r_aq[i_ctrl.axis] <= i_quo[SAMPLE_BITS-1:0];
            r_ar[i_ctrl.axis] <= i_rem;
        end
    end

endmodule

// ----- sv/imu_sample_gap_filler.sv -----
// IMU gap filler. Takes one timestamped six-axis sample per input word and
// holds the previous one. When the time gap to the held sample exceeds
// max_gap_ticks, it first emits n = floor(gap / max_gap_ticks) evenly spaced
// interpolated samples (n capped at MAX_FILL, flagged in tuser), then the
// sample itself with tlast set. tlast on the input ends the sequence: the
// next sample passes straight through. The one-bit-per-cycle divider splits the
// time gap and each axis difference by n + 1. s_axis_tready is high only while
// idle, so no new word is taken until the last word and its fills have gone to
// the output register; output stalls delay this further.
module imu_sample_gap_filler
    import imu_gf_pkg::*;
#(
    parameter int MAX_FILL    = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32,
    localparam int PAY_W      = TIME_BITS + NUM_AXES * SAMPLE_BITS,
    localparam int DATA_W     = ((PAY_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,   // max_gap_ticks
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // sample_time, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [DATA_W-1:0] s_axis_tdata,
    input  logic              s_axis_tlast,    // end_of_sequence
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_time, out_accel_x/y/z, out_gyro_x/y/z
    output logic [DATA_W-1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser,    // is_filled, fill_saturated
    output logic              m_axis_tlast     // last_of_run
);

    localparam int NB    = $clog2(MAX_FILL + 1);
    localparam int DEN_W = $clog2(MAX_FILL + 2);
    localparam int CW    = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int NUM_W = (TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
    localparam int LEN_W = $clog2(NUM_W + 1);
    localparam logic [31:0] MAX_GAP_RESET = 32'd5000;

    t_state                        r_state, n_state;
    logic [31:0]                   r_max_gap, n_max_gap;
    logic                          r_have_prev, n_have_prev;
    logic                          r_out_valid, n_out_valid;
    logic [DATA_W-1:0]             r_out_data, n_out_data;
    logic [1:0]                    r_out_user, n_out_user;
    logic                          r_out_last, n_out_last;
    logic [TIME_BITS-1:0]          r_prev_time, n_prev_time;
    logic signed [SAMPLE_BITS-1:0] r_prev_axis [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] n_prev_axis [NUM_AXES];
    logic [TIME_BITS-1:0]          r_cur_time, n_cur_time;
    logic signed [SAMPLE_BITS-1:0] r_cur_axis [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] n_cur_axis [NUM_AXES];
    logic                          r_cur_eos, n_cur_eos;
    logic [TIME_BITS-1:0]          r_gap, n_gap;
    logic [TIME_BITS-1:0]          r_rem, n_rem;
    logic [NB-1:0]                 r_cnt, n_cnt;
    logic [NB-1:0]                 r_n, n_n;
    logic [NB-1:0]                 r_k, n_k;
    logic [DEN_W-1:0]              r_den, n_den;
    logic                          r_sat, n_sat;
    logic [NUM_AXES-1:0]           r_neg, n_neg;
    logic [SAMPLE_BITS-1:0]        r_mag [NUM_AXES];
    logic [SAMPLE_BITS-1:0]        n_mag [NUM_AXES];
    logic [AXIS_IDX_W-1:0]         r_axis_idx, n_axis_idx;

    logic [31:0]                   max_gap;
    logic [CW:0]                   cnt_sub;
    logic                          cnt_ge;
    logic                          cnt_eq;
    logic [TIME_BITS:0]            gap_sub;
    logic [SAMPLE_BITS:0]          axis_diff [NUM_AXES];
    logic [SAMPLE_BITS:0]          axis_abs [NUM_AXES];
    logic                          out_free;
    logic [AXIS_IDX_W-1:0]         next_axis;
    logic [DATA_W-1:0]             fill_data;
    logic [DATA_W-1:0]             cur_data;

    logic                          div_start;
    logic [NUM_W-1:0]              div_num;
    logic [LEN_W-1:0]              div_len;
    logic [DEN_W-1:0]              div_den;
    logic                          div_busy;
    logic                          div_done;
    logic [NUM_W-1:0]              div_quo;
    logic [DEN_W-1:0]              div_rem;

    t_step_ctrl                    step;
    logic [TIME_BITS-1:0]          step_time;
    logic signed [SAMPLE_BITS-1:0] step_axis [NUM_AXES];

    imu_gf_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_len   (div_len),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    imu_gf_stepper #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .DEN_W       (DEN_W),
        .NUM_W       (NUM_W)
    ) u_stepper (
        .i_clk       (i_clk),
        .i_ctrl      (step),
        .i_quo       (div_quo),
        .i_rem       (div_rem),
        .i_den       (r_den),
        .i_prev_time (r_prev_time),
        .i_prev_axis (r_prev_axis),
        .i_neg       (r_neg),
        .o_time      (step_time),
        .o_axis      (step_axis)
    );

    always_comb begin
        max_gap  = (r_max_gap == 32'd0) ? 32'd1 : r_max_gap;
        cnt_sub  = {1'b0, CW'(r_rem)} - {1'b0, CW'(max_gap)};
        cnt_ge   = !cnt_sub[CW];
        cnt_eq   = cnt_sub[CW-1:0] == '0;
        gap_sub  = {1'b0, r_cur_time} - {1'b0, r_prev_time};
        out_free = !r_out_valid || m_axis_tready;
        next_axis = (r_axis_idx == LAST_AXIS) ? r_axis_idx
                                              : r_axis_idx + AXIS_IDX_W'(1);
        fill_data = '0;
        cur_data  = '0;
        fill_data[TIME_BITS-1:0] = step_time;
        cur_data[TIME_BITS-1:0]  = r_cur_time;
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_diff[i] = {r_cur_axis[i][SAMPLE_BITS-1], r_cur_axis[i]}
                         - {r_prev_axis[i][SAMPLE_BITS-1], r_prev_axis[i]};
            axis_abs[i]  = axis_diff[i][SAMPLE_BITS] ? -axis_diff[i] : axis_diff[i];
            fill_data[TIME_BITS + i * SAMPLE_BITS +: SAMPLE_BITS] = step_axis[i];
            cur_data[TIME_BITS + i * SAMPLE_BITS +: SAMPLE_BITS]  = r_cur_axis[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_max_gap   = i_cfg_wr_en ? i_cfg_wr_data : r_max_gap;
        n_have_prev = r_have_prev;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        n_prev_time = r_prev_time;
        n_prev_axis = r_prev_axis;
        n_cur_time  = r_cur_time;
        n_cur_axis  = r_cur_axis;
        n_cur_eos   = r_cur_eos;
        n_gap       = r_gap;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_k         = r_k;
        n_den       = r_den;
        n_sat       = r_sat;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_axis_idx  = r_axis_idx;
        div_start   = 1'b0;
        div_num     = NUM_W'(r_mag[next_axis]) << (NUM_W - SAMPLE_BITS);
        div_len     = LEN_W'(SAMPLE_BITS);
        div_den     = r_den;
        step        = '0;
        s_axis_tready = r_state == S_IDLE;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cur_time = s_axis_tdata[TIME_BITS-1:0];
                    for (int i = 0; i < NUM_AXES; i++) begin
                        n_cur_axis[i] = s_axis_tdata[TIME_BITS + i * SAMPLE_BITS +: SAMPLE_BITS];
                    end
                    n_cur_eos = s_axis_tlast;
                    n_sat     = 1'b0;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    n_neg[i] = axis_diff[i][SAMPLE_BITS];
                    n_mag[i] = axis_abs[i][SAMPLE_BITS-1:0];
                end
                n_gap = gap_sub[TIME_BITS-1:0];
                n_rem = gap_sub[TIME_BITS-1:0];
                n_cnt = '0;
                // no fill after a sequence start or when time runs backwards
                n_state = (!r_have_prev || gap_sub[TIME_BITS]) ? S_LAST : S_COUNT;
            end
            S_COUNT: begin
                if ((r_cnt == '0) && (!cnt_ge || cnt_eq)) begin
                    n_state = S_LAST;
                end else if (!cnt_ge || (r_cnt == NB'(MAX_FILL))) begin
                    // fill count known: split the gap by n + 1
                    n_n       = r_cnt;
                    n_sat     = cnt_ge;
                    n_den     = DEN_W'(r_cnt) + DEN_W'(1);
                    n_k       = '0;
                    div_start = 1'b1;
                    div_num   = NUM_W'(r_gap) << (NUM_W - TIME_BITS);
                    div_len   = LEN_W'(TIME_BITS);
                    div_den   = DEN_W'(r_cnt) + DEN_W'(1);
                    step.clear = 1'b1;
                    n_state   = S_DIV_T;
                end else begin
                    n_rem = cnt_sub[TIME_BITS-1:0];
                    n_cnt = r_cnt + NB'(1);
                end
            end
            S_DIV_T: begin
                if (div_done) begin
                    step.load_time = 1'b1;
                    div_start  = 1'b1;
                    div_num    = NUM_W'(r_mag[FIRST_AXIS]) << (NUM_W - SAMPLE_BITS);
                    n_axis_idx = FIRST_AXIS;
                    n_state    = S_DIV_A;
                end
            end
            S_DIV_A: begin
                if (div_done) begin
                    step.load_axis = 1'b1;
                    step.axis      = r_axis_idx;
                    if (r_axis_idx == LAST_AXIS) begin
                        n_state = S_ADV;
                    end else begin
                        div_start  = 1'b1;
                        n_axis_idx = next_axis;
                    end
                end
            end
            S_ADV: begin
                step.advance = 1'b1;
                n_k     = r_k + NB'(1);
                n_state = S_FILL;
            end
            S_FILL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = fill_data;
                    n_out_user  = {r_sat, 1'b1};
                    n_out_last  = 1'b0;
                    n_state     = (r_k == r_n) ? S_LAST : S_ADV;
                end
            end
            S_LAST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = cur_data;
                    n_out_user  = {r_sat, 1'b0};
                    n_out_last  = 1'b1;
                    n_prev_time = r_cur_time;
                    n_prev_axis = r_cur_axis;
                    n_have_prev = !r_cur_eos;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max_gap   <= MAX_GAP_RESET;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_time <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_prev_axis[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_max_gap   <= n_max_gap;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
            r_prev_time <= n_prev_time;
            r_prev_axis <= n_prev_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
        r_cur_time <= n_cur_time;
        r_cur_axis <= n_cur_axis;
        r_cur_eos  <= n_cur_eos;
        r_gap      <= n_gap;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_n        <= n_n;
        r_k        <= n_k;
        r_den      <= n_den;
        r_sat      <= n_sat;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_axis_idx <= n_axis_idx;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_T || r_state == S_DIV_A))
        else $error("divider result arrived outside a divide phase");

    a_fill_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_k != '0 && r_k <= r_n))
        else $error("fill index out of range");

    a_adv_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |-> (r_k < r_n))
        else $error("fill step past the fill count");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import imu_gf_pkg::*;

    localparam int FILL_CAP       = 15;
    localparam int SAMPLE_W       = 16;
    localparam int STAMP_W        = 32;
    localparam int DATA_W         = 128;
    localparam int IDLE_MAX       = 18;
    localparam int HOLD_CYCLES    = 700;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 30;

    typedef bit [NUM_AXES-1:0][SAMPLE_W-1:0] t_axes;

    typedef struct packed {
        bit [STAMP_W-1:0] stamp;
        t_axes            axes;
        bit               eos;
    } t_imu_word;

    typedef struct packed {
        bit [STAMP_W-1:0] stamp;
        t_axes            axes;
        bit               filled;
        bit               saturated;
        bit               last;
    } t_imu_result;

    // Predicts the output words of the gap filler and checks them in order.
    class gap_fill_tracker;
        bit [STAMP_W-1:0] gap_limit = 32'd5000;
        bit               held;
        bit [STAMP_W-1:0] held_stamp;
        t_axes            held_axes;
        t_imu_result      pending_outputs[$];
        int               errors;

        function int pending();
            return pending_outputs.size();
        endfunction

        function void note_sample(t_imu_word w);
            bit [63:0]   gap, step, fills, div, quot, rem, stamp_k;
            longint      lo, hi, num, frac, dl, kl;
            bit          sat;
            int          k, i;
            t_imu_result r;
            gap   = 0;
            fills = 0;
            sat   = 1'b0;
            if (held && w.stamp >= held_stamp) begin
                gap  = 64'(w.stamp) - 64'(held_stamp);
                step = (gap_limit == 0) ? 64'd1 : 64'(gap_limit);
                if (gap > step) begin
                    fills = gap / step;
                    if (fills > FILL_CAP) begin
                        fills = FILL_CAP;
                        sat   = 1'b1;
                    end
                end
            end
            div  = fills + 1;
            quot = gap / div;
            rem  = gap % div;
            dl   = longint'(div);
            for (k = 1; k <= int'(fills); k++) begin
                kl = k;
                // floor(k * gap / D) without a wide product
                stamp_k = 64'(held_stamp) + quot * 64'(k) + (rem * 64'(k)) / div;
                r.stamp = stamp_k[STAMP_W-1:0];
                for (i = 0; i < NUM_AXES; i++) begin
                    lo  = $signed(held_axes[i]);
                    hi  = $signed(w.axes[i]);
                    num = (hi - lo) * kl;
                    // round half away from zero
                    if (num >= 0)
                        frac = (num + dl / 2) / dl;
                    else
                        frac = -((-num + dl / 2) / dl);
                    num = lo + frac;
                    r.axes[i] = num[SAMPLE_W-1:0];
                end
                r.filled    = 1'b1;
                r.saturated = sat;
                r.last      = 1'b0;
                pending_outputs = {pending_outputs, r};
            end
            r.stamp     = w.stamp;
            r.axes      = w.axes;
            r.filled    = 1'b0;
            r.saturated = sat;
            r.last      = 1'b1;
            pending_outputs = {pending_outputs, r};
            held_stamp = w.stamp;
            held_axes  = w.axes;
            held       = !w.eos;
        endfunction

        function void compare(string field, bit [31:0] want, bit [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_output(t_imu_result got);
            t_imu_result want;
            int          i;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected output word, expected none, got time %0h",
                         $time, got.stamp);
                return;
            end
            want = pending_outputs.pop_front();
            compare("out_time", want.stamp, got.stamp);
            for (i = 0; i < NUM_AXES; i++)
                compare($sformatf("axis %0d", i), 32'(want.axes[i]), 32'(got.axes[i]));
            compare("is_filled", 32'(want.filled), 32'(got.filled));
            compare("fill_saturated", 32'(want.saturated), 32'(got.saturated));
            compare("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [31:0]       i_cfg_wr_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // sample_time, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;   // end_of_sequence
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // out_time, out_accel_x/y/z, out_gyro_x/y/z
    logic [DATA_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;           // is_filled, fill_saturated
    logic              m_axis_tlast;           // last_of_run

    gap_fill_tracker   tracker = new();
    t_imu_word         seen_word;
    t_imu_result       seen_result;
    int                words_sent;
    int                words_received;
    int                quiet_cycles;
    bit                hold_request;
    bit                hold_done;
    bit                seq_open;
    bit [STAMP_W-1:0]  last_stamp;

    imu_sample_gap_filler #(
        .MAX_FILL    (FILL_CAP),
        .SAMPLE_BITS (SAMPLE_W),
        .TIME_BITS   (STAMP_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            seen_word.stamp = s_axis_tdata[STAMP_W-1:0];
            seen_word.axes  = s_axis_tdata[STAMP_W +: NUM_AXES * SAMPLE_W];
            seen_word.eos   = s_axis_tlast;
            tracker.note_sample(seen_word);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result.stamp     = m_axis_tdata[STAMP_W-1:0];
            seen_result.axes      = m_axis_tdata[STAMP_W +: NUM_AXES * SAMPLE_W];
            seen_result.filled    = m_axis_tuser[0];
            seen_result.saturated = m_axis_tuser[1];
            seen_result.last      = m_axis_tlast;
            tracker.check_output(seen_result);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stalls per word, bursts of full rate, one long hold-off
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (hold_request && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if ((words_received / 24) % 3 == 0) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, IDLE_MAX);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid)
                @(posedge i_clk);
            words_received++;
            @(negedge i_clk);
        end
    end

    function automatic t_axes rand_axes();
        t_axes v;
        int    i;
        for (i = 0; i < NUM_AXES; i++) begin
            case ($urandom_range(0, 7))
                0:       v[i] = 16'h8000;
                1:       v[i] = 16'h7fff;
                2:       v[i] = 16'($urandom_range(0, 15)) - 16'd8;
                default: v[i] = 16'($urandom);
            endcase
        end
        return v;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input bit [STAMP_W-1:0] stamp, input t_axes axes,
                               input bit eos);
        int idle;
        idle = ((words_sent / 16) % 3 == 0) ? 0 : $urandom_range(0, IDLE_MAX);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {axes, stamp};
        s_axis_tlast  <= eos;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        words_sent++;
        last_stamp = stamp;
        seq_open   = !eos;
        @(negedge i_clk);
    endtask

    // write max_gap_ticks once the block has drained
    task automatic set_gap_limit(input bit [31:0] value);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.gap_limit = value;
    endtask

    task automatic run_random(input int count, input bit with_hold);
        bit [STAMP_W-1:0] g, stamp;
        int               j;
        g = (tracker.gap_limit == 0) ? 32'd1 : tracker.gap_limit;
        for (j = 0; j < count; j++) begin
            if (!seq_open) begin
                stamp = $urandom;
            end else begin
                case ($urandom_range(0, 9))
                    0:       stamp = last_stamp;
                    1, 2, 3: stamp = last_stamp + $urandom_range(0, g);
                    4, 5, 6: stamp = last_stamp + 32'(64'($urandom_range(1, 4)) * g
                                     + 64'($urandom_range(0, g - 1)));
                    7:       stamp = last_stamp + 32'(64'($urandom_range(5, 20)) * g
                                     + 64'($urandom_range(0, g - 1)));
                    8:       stamp = last_stamp + $urandom;
                    default: stamp = last_stamp - $urandom_range(1, 5000);
                endcase
            end
            // stall the output while words keep coming in
            if (with_hold && j == count / 3)
                hold_request = 1'b1;
            send_sample(stamp, rand_axes(), $urandom_range(0, 11) == 0);
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit of 5000
        send_sample(32'd0, {NUM_AXES{16'h8000}}, 1'b0);
        send_sample(32'd5000, {NUM_AXES{16'h7fff}}, 1'b0);          // gap equals limit
        send_sample(32'd10001, {NUM_AXES{16'h8000}}, 1'b0);         // one fill
        send_sample(32'd25001, {NUM_AXES{16'h7fff}}, 1'b0);         // three fills
        send_sample(32'd225001, {NUM_AXES{16'h8000}}, 1'b0);        // capped
        send_sample(32'd225001, {NUM_AXES{16'h0000}}, 1'b0);        // zero gap
        send_sample(32'd100, {NUM_AXES{16'hffff}}, 1'b0);           // time goes back
        send_sample(32'd75100, {NUM_AXES{16'h0003}}, 1'b0);         // exactly the cap
        send_sample(32'd155100, {NUM_AXES{16'hfffd}}, 1'b0);        // one past the cap
        send_sample(32'd161100, rand_axes(), 1'b1);                 // end of sequence
        send_sample(32'hffff_ffff, {16'h5555, 16'haaaa, 16'h5555,
                                    16'haaaa, 16'h5555, 16'haaaa}, 1'b0);
        send_sample(32'hffff_ffff, rand_axes(), 1'b1);
        send_sample(32'd0, {16'haaaa, 16'h5555, 16'haaaa,
                            16'h5555, 16'haaaa, 16'h5555}, 1'b0);
        send_sample(32'hffff_ffff, rand_axes(), 1'b0);
        send_sample(32'hffff_0000, {NUM_AXES{16'h0000}}, 1'b0);
        send_sample(32'hffff_2710, {16'h5555, 16'haaaa, 16'h7fff,
                                    16'h8000, 16'h0001, 16'hfffe}, 1'b0);
        send_sample(32'hffff_4e20, rand_axes(), 1'b1);

        // a limit of zero acts as one
        set_gap_limit(32'd0);
        send_sample(32'd1000, rand_axes(), 1'b0);
        send_sample(32'd1001, rand_axes(), 1'b0);
        send_sample(32'd1003, rand_axes(), 1'b0);
        send_sample(32'd1010, rand_axes(), 1'b0);
        send_sample(32'd1100, rand_axes(), 1'b1);

        set_gap_limit(32'd1);
        run_random(PHASE_ITEMS, 1'b0);
        set_gap_limit(32'hffff_ffff);
        run_random(PHASE_ITEMS, 1'b0);
        set_gap_limit($urandom_range(1000, 20000));
        run_random(PHASE_ITEMS, 1'b1);
        set_gap_limit($urandom_range(2, 64));
        run_random(PHASE_ITEMS, 1'b0);
        set_gap_limit($urandom_range(100000, 3000000));
        run_random(PHASE_ITEMS, 1'b0);
        set_gap_limit(32'd5000);
        run_random(PHASE_ITEMS, 1'b0);
        set_gap_limit($urandom_range(2, 300));
        run_random(PHASE_ITEMS, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
